>>> src/kmc_pkg.sv
// Shared types and constants of the 1-D k-means intensity clusterer.
package kmc_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int INDEX_W      = 12;
    localparam int LABEL_W      = 4;
    localparam int COUNT_W      = 13;
    localparam int K_W          = 5;
    localparam int ITER_W       = 8;
    localparam int SUM_W        = 29;
    localparam int MEAN_W       = 25;
    localparam int FRAC_BITS    = 8;
    localparam int DIST_W       = 26;
    localparam int MAX_SAMPLES  = 4096;
    localparam int MAX_CLUSTERS = 16;
    localparam int DIVIDEND_W   = SUM_W - 1 + FRAC_BITS;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 13;

    // command codes
    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_RUN  = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_RANGE   = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CLUSTERS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ITERS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES  = 2'd2;

    typedef enum logic [2:0] {
        OP_IDLE,
        OP_CLEAR,
        OP_PART,
        OP_INIT,
        OP_SUM,
        OP_MEAN,
        OP_RELABEL
    } op_t;

    typedef struct packed {
        logic [1:0]                  cmd;
        logic [INDEX_W-1:0]          sample_index;
        logic signed [SAMPLE_W-1:0]  sample_value;
    } item_t;

    typedef struct packed {
        logic [LABEL_W-1:0] label;
        logic [COUNT_W-1:0] cluster_size;
        logic [1:0]         status;
    } result_t;

    typedef struct packed {
        op_t                         op;
        logic                        start;
        logic                        load_we;
        logic [INDEX_W-1:0]          index;
        logic signed [SAMPLE_W-1:0]  value;
    } ctrl_cmd_t;

    typedef struct packed {
        logic               done;
        logic [LABEL_W-1:0] label;
        logic [COUNT_W-1:0] cluster_size;
    } dp_stat_t;

endpackage

>>> src/kmc_stream_if.sv
// Valid/ready stream interface carrying one payload beat.
interface kmc_stream_if #(parameter type payload_t = logic [0:0]);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> src/kmc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kmc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/kmc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module kmc_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [kmc_pkg::DIVIDEND_W-1:0]   dividend,
    input  logic [kmc_pkg::COUNT_W-1:0]      divisor,
    output logic                             done,
    output logic [kmc_pkg::DIVIDEND_W-1:0]   quotient
);

    localparam int CNT_W = $clog2(kmc_pkg::DIVIDEND_W);
    localparam logic [CNT_W-1:0] STEP_LAST = CNT_W'(kmc_pkg::DIVIDEND_W - 1);

    logic                             busy_reg;
    logic                             done_reg;
    logic [CNT_W-1:0]                 cnt_reg;
    logic [kmc_pkg::COUNT_W-1:0]      rem_reg;
    logic [kmc_pkg::COUNT_W-1:0]      div_reg;
    logic [kmc_pkg::DIVIDEND_W-1:0]   quo_reg;
    logic [kmc_pkg::COUNT_W:0]        shifted;
    logic                             fits;

    // trial subtract of the shifted remainder
    assign shifted = {rem_reg, quo_reg[kmc_pkg::DIVIDEND_W-1]};
    assign fits    = shifted >= {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            // pulse after the last quotient bit
            done_reg <= !start && busy_reg && (cnt_reg == STEP_LAST);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                div_reg  <= divisor;
                quo_reg  <= dividend;
            end
            else if (busy_reg)
            begin
                rem_reg <= fits ? kmc_pkg::COUNT_W'(shifted - {1'b0, div_reg})
                                : shifted[kmc_pkg::COUNT_W-1:0];
                quo_reg <= {quo_reg[kmc_pkg::DIVIDEND_W-2:0], fits};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == STEP_LAST)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> src/kmc_dpath.sv
// Datapath: sample and label stores, cluster statistics, partition, mean, relabel.
module kmc_dpath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  kmc_pkg::ctrl_cmd_t           cmd,
    input  logic [kmc_pkg::K_W-1:0]      k_eff,
    input  logic [kmc_pkg::COUNT_W-1:0]  n_eff,
    output kmc_pkg::dp_stat_t            stat
);

    localparam int NC = kmc_pkg::MAX_CLUSTERS;
    localparam int LW = kmc_pkg::LABEL_W;
    localparam int CW = kmc_pkg::COUNT_W;
    localparam int XW = kmc_pkg::SAMPLE_W + kmc_pkg::FRAC_BITS;

    logic [CW-1:0]                         j_reg;
    logic [CW-1:0]                         chunk_reg;
    logic [CW-1:0]                         part_reg;
    logic [LW-1:0]                         lbl_reg;
    logic [LW-1:0]                         c_reg;
    logic [LW-1:0]                         best_reg;
    logic [kmc_pkg::DIST_W-1:0]            bestd_reg;
    logic                                  found_reg;
    logic                                  fetch_reg;
    logic                                  issue_reg;
    logic                                  rdv_reg;
    logic                                  lastq_reg;
    logic                                  wait_reg;
    logic                                  neg_reg;
    logic signed [kmc_pkg::SUM_W-1:0]      sums_reg  [NC];
    logic [CW-1:0]                         sizes_reg [NC];
    logic [CW-1:0]                         acc_reg   [NC];
    logic [CW-1:0]                         acc_next  [NC];
    logic signed [kmc_pkg::MEAN_W-1:0]     means_reg [NC];
    logic [NC-1:0]                         valid_reg;

    logic signed [kmc_pkg::SAMPLE_W-1:0]   smp_q;
    logic [LW-1:0]                         lbl_q;
    logic                                  lbl_we;
    logic [LW-1:0]                         lbl_wdata;
    logic [kmc_pkg::INDEX_W-1:0]           lbl_raddr;
    logic [LW-1:0]                         k_last;
    logic [CW-1:0]                         n_last;
    logic                                  j_last;
    logic                                  c_last;
    logic [LW-1:0]                         init_label;
    logic [LW-1:0]                         sel_idx;
    logic [CW-1:0]                         size_sel;
    logic signed [kmc_pkg::SUM_W-1:0]      sum_sel;
    logic signed [kmc_pkg::SUM_W-1:0]      sum_abs;
    logic signed [XW-1:0]                  x_val;
    logic signed [kmc_pkg::DIST_W-1:0]     diff;
    logic [kmc_pkg::DIST_W-1:0]            dabs;
    logic                                  take;
    logic [LW-1:0]                         best_now;
    logic                                  div_start;
    logic                                  div_done;
    logic [kmc_pkg::DIVIDEND_W-1:0]        div_dividend;
    logic [CW-1:0]                         div_divisor;
    logic [kmc_pkg::DIVIDEND_W-1:0]        div_quo;
    logic [kmc_pkg::MEAN_W-1:0]            q_mag;
    logic                                  work;

    // stores
    kmc_ram #(.WIDTH(kmc_pkg::SAMPLE_W), .DEPTH(kmc_pkg::MAX_SAMPLES)) u_sample_ram (
        .clk   (clk),
        .we    (cmd.load_we),
        .waddr (cmd.index),
        .wdata (cmd.value),
        .raddr (j_reg[kmc_pkg::INDEX_W-1:0]),
        .rdata (smp_q)
    );

    kmc_ram #(.WIDTH(LW), .DEPTH(kmc_pkg::MAX_SAMPLES)) u_label_ram (
        .clk   (clk),
        .we    (lbl_we),
        .waddr (j_reg[kmc_pkg::INDEX_W-1:0]),
        .wdata (lbl_wdata),
        .raddr (lbl_raddr),
        .rdata (lbl_q)
    );

    // shared divider: partition size and cluster means
    kmc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign work      = !cmd.start;
    assign k_last    = LW'(k_eff - 1'b1);
    assign n_last    = n_eff - 1'b1;
    assign j_last    = j_reg == n_last;
    assign c_last    = c_reg == k_last;
    assign lbl_raddr = (cmd.op == kmc_pkg::OP_SUM) ? j_reg[kmc_pkg::INDEX_W-1:0] : cmd.index;

    // one read port into the per-cluster statistics
    assign sel_idx  = (cmd.op == kmc_pkg::OP_MEAN) ? c_reg : lbl_q;
    assign size_sel = sizes_reg[sel_idx];
    assign sum_sel  = sums_reg[sel_idx];
    assign sum_abs  = sum_sel[kmc_pkg::SUM_W-1] ? -sum_sel : sum_sel;

    // initial contiguous partition
    assign init_label = (part_reg == '0) ? k_last : lbl_reg;

    // distance of the fetched sample to the mean of cluster c
    assign x_val    = {smp_q, {kmc_pkg::FRAC_BITS{1'b0}}};
    assign diff     = kmc_pkg::DIST_W'(x_val) - kmc_pkg::DIST_W'(means_reg[c_reg]);
    assign dabs     = diff[kmc_pkg::DIST_W-1] ? kmc_pkg::DIST_W'(-diff) : kmc_pkg::DIST_W'(diff);
    assign take     = valid_reg[c_reg] && (!found_reg || dabs < bestd_reg);
    assign best_now = take ? c_reg : best_reg;

    // label store write
    always_comb
    begin
        lbl_we    = 1'b0;
        lbl_wdata = '0;
        case (cmd.op)
            kmc_pkg::OP_CLEAR:
            begin
                lbl_we = work;
            end
            kmc_pkg::OP_INIT:
            begin
                lbl_we    = work;
                lbl_wdata = init_label;
            end
            kmc_pkg::OP_RELABEL:
            begin
                lbl_we    = work && !fetch_reg && c_last;
                lbl_wdata = best_now;
            end
            default:
            begin
                lbl_we = 1'b0;
            end
        endcase
    end

    // cluster population counting
    always_comb
    begin
        for (int i = 0; i < NC; i++)
        begin
            acc_next[i] = acc_reg[i] + CW'(lbl_we && cmd.op != kmc_pkg::OP_CLEAR
                                          && lbl_wdata == LW'(i));
        end
    end

    // divider operands
    assign div_start = (cmd.op == kmc_pkg::OP_PART && cmd.start)
                    || (cmd.op == kmc_pkg::OP_MEAN && work && !wait_reg && size_sel != '0);
    assign div_dividend = (cmd.op == kmc_pkg::OP_PART)
                        ? kmc_pkg::DIVIDEND_W'(n_eff)
                        : {sum_abs[kmc_pkg::SUM_W-2:0], {kmc_pkg::FRAC_BITS{1'b0}}};
    assign div_divisor  = (cmd.op == kmc_pkg::OP_PART) ? CW'(k_eff) : size_sel;
    assign q_mag        = div_quo[kmc_pkg::MEAN_W-1:0];

    // phase completion
    always_comb
    begin
        case (cmd.op)
            kmc_pkg::OP_CLEAR:   stat.done = work && j_reg == CW'(kmc_pkg::MAX_SAMPLES - 1);
            kmc_pkg::OP_PART:    stat.done = div_done;
            kmc_pkg::OP_INIT:    stat.done = work && j_last;
            kmc_pkg::OP_SUM:     stat.done = rdv_reg && lastq_reg;
            kmc_pkg::OP_MEAN:    stat.done = work && c_last
                                      && ((!wait_reg && size_sel == '0) || (wait_reg && div_done));
            kmc_pkg::OP_RELABEL: stat.done = lbl_we && j_last;
            default:             stat.done = 1'b0;
        endcase
    end

    assign stat.label        = lbl_q;
    assign stat.cluster_size = size_sel;

    // phase sequencing and statistics
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            j_reg     <= '0;
            chunk_reg <= '0;
            part_reg  <= '0;
            lbl_reg   <= '0;
            c_reg     <= '0;
            best_reg  <= '0;
            bestd_reg <= '0;
            found_reg <= 1'b0;
            fetch_reg <= 1'b0;
            issue_reg <= 1'b0;
            rdv_reg   <= 1'b0;
            lastq_reg <= 1'b0;
            wait_reg  <= 1'b0;
            neg_reg   <= 1'b0;
            valid_reg <= '0;
            for (int i = 0; i < NC; i++)
            begin
                sums_reg[i]  <= '0;
                sizes_reg[i] <= '0;
                acc_reg[i]   <= '0;
                means_reg[i] <= '0;
            end
        end
        else
        begin
            case (cmd.op)
                kmc_pkg::OP_CLEAR:
                begin
                    j_reg <= cmd.start ? '0 : j_reg + 1'b1;
                end
                kmc_pkg::OP_PART:
                begin
                    if (div_done)
                    begin
                        part_reg <= div_quo[CW-1:0];
                    end
                end
                kmc_pkg::OP_INIT:
                begin
                    if (cmd.start)
                    begin
                        j_reg     <= '0;
                        lbl_reg   <= '0;
                        chunk_reg <= '0;
                        for (int i = 0; i < NC; i++)
                        begin
                            acc_reg[i] <= '0;
                        end
                    end
                    else
                    begin
                        j_reg <= j_reg + 1'b1;
                        for (int i = 0; i < NC; i++)
                        begin
                            acc_reg[i] <= acc_next[i];
                        end
                        if (chunk_reg == part_reg - 1'b1)
                        begin
                            chunk_reg <= '0;
                            if (lbl_reg != k_last)
                            begin
                                lbl_reg <= lbl_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            chunk_reg <= chunk_reg + 1'b1;
                        end
                        if (j_last)
                        begin
                            for (int i = 0; i < NC; i++)
                            begin
                                sizes_reg[i] <= acc_next[i];
                            end
                        end
                    end
                end
                kmc_pkg::OP_SUM:
                begin
                    if (cmd.start)
                    begin
                        j_reg     <= '0;
                        issue_reg <= 1'b1;
                        rdv_reg   <= 1'b0;
                        lastq_reg <= 1'b0;
                        for (int i = 0; i < NC; i++)
                        begin
                            sums_reg[i] <= '0;
                        end
                    end
                    else
                    begin
                        rdv_reg   <= issue_reg;
                        lastq_reg <= issue_reg && j_last;
                        if (issue_reg)
                        begin
                            j_reg     <= j_reg + 1'b1;
                            issue_reg <= !j_last;
                        end
                        if (rdv_reg)
                        begin
                            sums_reg[lbl_q] <= sum_sel + kmc_pkg::SUM_W'(smp_q);
                        end
                    end
                end
                kmc_pkg::OP_MEAN:
                begin
                    if (cmd.start)
                    begin
                        c_reg    <= '0;
                        wait_reg <= 1'b0;
                    end
                    else if (!wait_reg)
                    begin
                        if (size_sel == '0)
                        begin
                            valid_reg[c_reg] <= 1'b0;
                            means_reg[c_reg] <= '0;
                            if (!c_last)
                            begin
                                c_reg <= c_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            wait_reg <= 1'b1;
                            neg_reg  <= sum_sel[kmc_pkg::SUM_W-1];
                        end
                    end
                    else if (div_done)
                    begin
                        valid_reg[c_reg] <= 1'b1;
                        means_reg[c_reg] <= neg_reg ? -$signed(q_mag) : $signed(q_mag);
                        wait_reg         <= 1'b0;
                        if (!c_last)
                        begin
                            c_reg <= c_reg + 1'b1;
                        end
                    end
                end
                kmc_pkg::OP_RELABEL:
                begin
                    if (cmd.start)
                    begin
                        j_reg     <= '0;
                        fetch_reg <= 1'b1;
                        for (int i = 0; i < NC; i++)
                        begin
                            acc_reg[i] <= '0;
                        end
                    end
                    else if (fetch_reg)
                    begin
                        fetch_reg <= 1'b0;
                        c_reg     <= '0;
                        found_reg <= 1'b0;
                    end
                    else
                    begin
                        if (take)
                        begin
                            found_reg <= 1'b1;
                            best_reg  <= c_reg;
                            bestd_reg <= dabs;
                        end
                        if (c_last)
                        begin
                            fetch_reg <= 1'b1;
                            j_reg     <= j_reg + 1'b1;
                            for (int i = 0; i < NC; i++)
                            begin
                                acc_reg[i] <= acc_next[i];
                            end
                            if (j_last)
                            begin
                                for (int i = 0; i < NC; i++)
                                begin
                                    sizes_reg[i] <= acc_next[i];
                                end
                            end
                        end
                        else
                        begin
                            c_reg <= c_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    rdv_reg <= 1'b0;
                end
            endcase
        end
    end

endmodule

>>> src/kmc_ctrl.sv
// Controller: command decode, run sequencing and the result register.
module kmc_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    kmc_stream_if.sink                    items,
    kmc_stream_if.source                  results,
    input  logic [kmc_pkg::ITER_W-1:0]    iters,
    input  logic [kmc_pkg::COUNT_W-1:0]   n_eff,
    input  kmc_pkg::dp_stat_t             stat,
    output kmc_pkg::ctrl_cmd_t            cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_PART,
        S_INIT,
        S_SUM,
        S_MEAN,
        S_RELABEL
    } state_t;

    state_t                        state_reg;
    state_t                        state_next;
    logic                          start_reg;
    logic                          start_next;
    logic [kmc_pkg::ITER_W-1:0]    iter_reg;
    logic [kmc_pkg::ITER_W-1:0]    iter_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    kmc_pkg::result_t              out_reg;
    kmc_pkg::result_t              out_next;
    logic                          items_ready;
    logic                          accept;
    logic                          in_range;
    kmc_pkg::item_t                item;
    kmc_pkg::op_t                  op;

    assign item        = items.payload;
    assign items_ready = (state_reg == S_IDLE) && (!out_valid_reg || results.ready);
    assign items.ready = items_ready;
    assign accept      = items.valid && items_ready;
    assign in_range    = {1'b0, item.sample_index} < n_eff;

    // phase handed to the datapath
    always_comb
    begin
        case (state_reg)
            S_CLEAR:   op = kmc_pkg::OP_CLEAR;
            S_PART:    op = kmc_pkg::OP_PART;
            S_INIT:    op = kmc_pkg::OP_INIT;
            S_SUM:     op = kmc_pkg::OP_SUM;
            S_MEAN:    op = kmc_pkg::OP_MEAN;
            S_RELABEL: op = kmc_pkg::OP_RELABEL;
            default:   op = kmc_pkg::OP_IDLE;
        endcase
    end

    assign cmd.op      = op;
    assign cmd.start   = start_reg;
    assign cmd.load_we = accept && item.cmd == kmc_pkg::CMD_LOAD;
    assign cmd.index   = item.sample_index;
    assign cmd.value   = item.sample_value;

    assign results.valid   = out_valid_reg;
    assign results.payload = out_reg;

    // next state and result register contents
    always_comb
    begin
        state_next     = state_reg;
        start_next     = 1'b0;
        iter_next      = iter_reg;
        out_valid_next = out_valid_reg && !results.ready;
        out_next       = out_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (stat.done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    out_next = '0;
                    case (item.cmd)
                        kmc_pkg::CMD_LOAD:
                        begin
                            out_valid_next = 1'b1;
                        end
                        kmc_pkg::CMD_RUN:
                        begin
                            state_next = S_PART;
                            start_next = 1'b1;
                        end
                        kmc_pkg::CMD_READ:
                        begin
                            if (in_range)
                            begin
                                state_next = S_READ;
                            end
                            else
                            begin
                                out_valid_next  = 1'b1;
                                out_next.status = kmc_pkg::ST_RANGE;
                            end
                        end
                        default:
                        begin
                            out_valid_next  = 1'b1;
                            out_next.status = kmc_pkg::ST_UNKNOWN;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                out_valid_next        = 1'b1;
                out_next.label        = stat.label;
                out_next.cluster_size = stat.cluster_size;
                out_next.status       = kmc_pkg::ST_OK;
                state_next            = S_IDLE;
            end
            S_PART:
            begin
                if (stat.done)
                begin
                    state_next = S_INIT;
                    start_next = 1'b1;
                end
            end
            S_INIT:
            begin
                if (stat.done)
                begin
                    iter_next = '0;
                    if (iters == '0)
                    begin
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_SUM;
                        start_next = 1'b1;
                    end
                end
            end
            S_SUM:
            begin
                if (stat.done)
                begin
                    state_next = S_MEAN;
                    start_next = 1'b1;
                end
            end
            S_MEAN:
            begin
                if (stat.done)
                begin
                    state_next = S_RELABEL;
                    start_next = 1'b1;
                end
            end
            S_RELABEL:
            begin
                if (stat.done)
                begin
                    iter_next = iter_reg + 1'b1;
                    if (iter_reg == iters - 1'b1)
                    begin
                        out_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_SUM;
                        start_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state machine and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            start_reg     <= 1'b1;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            start_reg     <= start_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

`ifndef SYNTH
    // a read result is formed only into an empty result register
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |-> !out_valid_reg)
        else $error("read result would overwrite a pending beat");

    // a run command starts the partition phase
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.cmd == kmc_pkg::CMD_RUN) |=> (state_reg == S_PART && start_reg))
        else $error("run command did not start partition");

    // no beat is taken while the label store is being cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> !items_ready)
        else $error("input accepted during label clear");
`endif

endmodule

>>> src/kmeans_1d_intensity_clusterer.sv
// Top level of the 1-D k-means intensity clusterer.
//
// Input channel items carries one command per beat: load (write a 16-bit
// sample at sample_index), run (cluster the first sample_count samples into
// cluster_count groups, iteration_count rounds) or read (label of a sample
// and the size of its cluster). Every command returns exactly one beat on
// results. Configuration is written through cfg_we/cfg_index/cfg_data while
// the block is idle.
// Load and rejected commands are answered straight from the result register;
// a read first passes through the label store. A run divides n by k for the
// chunk size and makes one pass over the samples for the initial labels;
// each iteration then makes a sum pass, a divide per non-empty cluster mean
// and a relabel pass that holds every sample against each of the k means.
// One command is worked on at a time; a new beat is taken only while the
// controller is idle and the result register is empty or unloads that cycle.
// After reset the label store is cleared entry by entry, during which no
// input beat is taken. A stalled receiver holds the result register and
// the block stops taking input until that beat leaves.
module kmeans_1d_intensity_clusterer (
    input  logic                               clk,
    input  logic                               rst_n,
    kmc_stream_if.sink                         items,
    kmc_stream_if.source                       results,
    input  logic                               cfg_we,
    input  logic [kmc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [kmc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [kmc_pkg::K_W-1:0]      cluster_count_reg;
    logic [kmc_pkg::ITER_W-1:0]   iteration_count_reg;
    logic [kmc_pkg::COUNT_W-1:0]  sample_count_reg;
    logic [kmc_pkg::K_W-1:0]      k_eff;
    logic [kmc_pkg::COUNT_W-1:0]  n_eff;
    kmc_pkg::ctrl_cmd_t           cmd;
    kmc_pkg::dp_stat_t            stat;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cluster_count_reg   <= kmc_pkg::K_W'(2);
            iteration_count_reg <= kmc_pkg::ITER_W'(10);
            sample_count_reg    <= kmc_pkg::COUNT_W'(kmc_pkg::MAX_SAMPLES);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                kmc_pkg::CFG_CLUSTERS: cluster_count_reg   <= cfg_data[kmc_pkg::K_W-1:0];
                kmc_pkg::CFG_ITERS:    iteration_count_reg <= cfg_data[kmc_pkg::ITER_W-1:0];
                kmc_pkg::CFG_SAMPLES:  sample_count_reg    <= cfg_data;
                default:               ;
            endcase
        end
    end

    // clamp k and n into their working ranges
    always_comb
    begin
        if (cluster_count_reg == '0)
        begin
            k_eff = kmc_pkg::K_W'(1);
        end
        else if (cluster_count_reg > kmc_pkg::K_W'(kmc_pkg::MAX_CLUSTERS))
        begin
            k_eff = kmc_pkg::K_W'(kmc_pkg::MAX_CLUSTERS);
        end
        else
        begin
            k_eff = cluster_count_reg;
        end

        if (sample_count_reg == '0)
        begin
            n_eff = kmc_pkg::COUNT_W'(1);
        end
        else if (sample_count_reg > kmc_pkg::COUNT_W'(kmc_pkg::MAX_SAMPLES))
        begin
            n_eff = kmc_pkg::COUNT_W'(kmc_pkg::MAX_SAMPLES);
        end
        else
        begin
            n_eff = sample_count_reg;
        end
    end

    kmc_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items),
        .results (results),
        .iters   (iteration_count_reg),
        .n_eff   (n_eff),
        .stat    (stat),
        .cmd     (cmd)
    );

    kmc_dpath u_dpath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .k_eff (k_eff),
        .n_eff (n_eff),
        .stat  (stat)
    );

endmodule
